// ===== rtl/rfd_pkg.sv =====
// Shared types and constants for the RPC frame deframer.
// Used by rfd_in_stage, rfd_parser, rfd_out_stage and rpc_frame_deframer.
// No dependencies.
package rfd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 4096;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned EVENT_W   = 2;
    localparam int unsigned UUID_W    = 16;
    localparam int unsigned TYPE_W    = 8;
    localparam int unsigned FLAG_W    = 8;
    localparam int unsigned CMD_W     = 16;
    localparam int unsigned PLEN_W    = 13;
    localparam int unsigned ERR_W     = 2;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned CRC_LEN_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // tdata of the result channel: fields plus one pad bit to a byte boundary
    localparam int unsigned M_TDATA_W = 72;

    localparam logic [15:0]          SYNC_WORD     = 16'hCAFE;
    localparam logic [LEN_W-1:0]     LEN_FIELD_MAX = 32'd8191;
    localparam logic [CRC_LEN_W-1:0] CRC_LEN_MAX   = 3'd4;

    localparam logic [CRC_LEN_W-1:0] CRC_LEN_RST    = 3'd0;
    localparam logic [TYPE_W-1:0]    TYPE_COUNT_RST = 8'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT = 2'd1;

    // result kinds
    localparam logic [EVENT_W-1:0] EV_HEADER  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD = 2'd1;
    localparam logic [EVENT_W-1:0] EV_CRC     = 2'd2;
    localparam logic [EVENT_W-1:0] EV_ERROR   = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SYNC    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TYPE    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_BIG = 2'd2;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [UUID_W-1:0]  msg_uuid;
        logic [TYPE_W-1:0]  msg_type;
        logic [FLAG_W-1:0]  encrypt_flag;
        logic [CMD_W-1:0]   command_id;
        logic [PLEN_W-1:0]  payload_len;
        logic [ERR_W-1:0]   error_code;
        logic               frame_last;
    } result_t;

endpackage

// ===== rtl/rpc_frame_deframer.sv =====
// Top level of the RPC frame deframer: input register, parser, result register.
// Depends on rfd_pkg, rfd_in_stage, rfd_parser, rfd_out_stage.
//
//   channel  dir  beat moves                     fields
//   s_       in   one received byte              tdata[7:0] rx_data
//   m_       out  one parse result               tdata, tuser event, tlast frame end
//   cfg_     in   one register write             cfg_index, cfg_data
//
// One byte per cycle sustained while m_tready does not stall; a byte that is taken sits in the
// input register while the parser reads it, and its result is loaded into the result register for m_.
// Reset (aresetn low, synchronous) returns the parser to sync, crc_len to 0, type_count to 2.
// A stall on m_tready backs up through the result register to s_tready; no beat is dropped.
// Bytes that produce no result pass through without using a result slot.
module rpc_frame_deframer #(
    parameter int unsigned MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rfd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_data
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] data_byte, [23:8] msg_uuid, [31:24] msg_type, [39:32] encrypt_flag,
    // [55:40] command_id, [68:56] payload_len, [70:69] error_code, [71] zero
    output logic [rfd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [rfd_pkg::EVENT_W-1:0]    m_tuser,   // [1:0] event_res
    output logic                          m_tlast,   // frame_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rfd_pkg::*;

    logic              advance;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              res_valid;
    result_t           res;

    rfd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    rfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    rfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/rfd_in_stage.sv =====
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on rfd_pkg.
module rfd_in_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rfd_pkg::BYTE_W-1:0] s_tdata,
    input  logic                      advance,
    output logic                      in_valid,
    output logic [rfd_pkg::BYTE_W-1:0] in_byte
);
    import rfd_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (take) begin
            valid_next = 1'b1;
            byte_next  = s_tdata;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== rtl/rfd_parser.sv =====
// Frame parser: sync check, header fields, payload and CRC counting, config registers.
// Depends on rfd_pkg.
module rfd_parser #(
    parameter int unsigned MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic [rfd_pkg::BYTE_W-1:0]     in_byte,
    input  logic                          advance,
    output logic                          res_valid,
    output rfd_pkg::result_t              res
);
    import rfd_pkg::*;

    // counter must reach MAX_PAYLOAD in the payload and 4 in the length field
    localparam int unsigned CNT_RAW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned CNT_W   = (CNT_RAW < 3) ? 3 : CNT_RAW;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_SYNC, PH_UUID, PH_TYPE, PH_FLAG, PH_CMD, PH_LEN, PH_PAYLOAD, PH_CRC
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0]    sync_hi_reg, sync_hi_next;
    logic [UUID_W-1:0]    uuid_reg, uuid_next;
    logic [TYPE_W-1:0]    type_reg, type_next;
    logic [FLAG_W-1:0]    flag_reg, flag_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [CRC_LEN_W-1:0] crc_len_reg;
    logic [TYPE_W-1:0]    type_count_reg;

    logic                 step;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CRC_LEN_W-1:0] crc_eff;
    logic [LEN_W-1:0]     len_shift;
    logic [PLEN_W-1:0]    len_sat;
    logic                 emit;
    logic                 hdr;
    logic [EVENT_W-1:0]   ev;
    logic [ERR_W-1:0]     err;
    logic                 last;

    assign cfg_ready = 1'b1;
    assign step      = in_valid && advance;
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign crc_eff   = (crc_len_reg > CRC_LEN_MAX) ? CRC_LEN_MAX : crc_len_reg;
    assign len_shift = {length_reg[LEN_W-BYTE_W-1:0], in_byte};
    assign len_sat   = (length_reg > LEN_FIELD_MAX) ? LEN_FIELD_MAX[PLEN_W-1:0]
                                                    : length_reg[PLEN_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sync_hi_next = sync_hi_reg;
        uuid_next    = uuid_reg;
        type_next    = type_reg;
        flag_next    = flag_reg;
        cmd_next     = cmd_reg;
        length_next  = length_reg;
        emit         = 1'b0;
        hdr          = 1'b1;
        ev           = EV_HEADER;
        err          = ERR_NONE;
        last         = 1'b0;
        unique case (phase_reg)
            PH_SYNC: begin
                // bytes are checked as aligned pairs
                if (count_reg == '0) begin
                    sync_hi_next = in_byte;
                    count_next   = cnt_inc;
                end else begin
                    count_next = '0;
                    if ({sync_hi_reg, in_byte} == SYNC_WORD) begin
                        uuid_next   = '0;
                        length_next = '0;
                        phase_next  = PH_UUID;
                    end else begin
                        emit = 1'b1;
                        hdr  = 1'b0;
                        ev   = EV_ERROR;
                        err  = ERR_SYNC;
                    end
                end
            end
            PH_UUID: begin
                uuid_next = {uuid_reg[UUID_W-BYTE_W-1:0], in_byte};
                if (count_reg == '0) begin
                    count_next = cnt_inc;
                end else begin
                    count_next = '0;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = in_byte;
                count_next = '0;
                if (in_byte < type_count_reg) begin
                    phase_next = PH_FLAG;
                end else begin
                    phase_next = PH_SYNC;
                    emit       = 1'b1;
                    ev         = EV_ERROR;
                    err        = ERR_TYPE;
                    last       = 1'b1;
                end
            end
            PH_FLAG: begin
                flag_next  = in_byte;
                count_next = '0;
                phase_next = PH_CMD;
            end
            PH_CMD: begin
                cmd_next = {cmd_reg[CMD_W-BYTE_W-1:0], in_byte};
                if (count_reg == '0) begin
                    count_next = cnt_inc;
                end else begin
                    count_next = '0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                length_next = len_shift;
                if (cnt_inc < CNT_W'(4)) begin
                    count_next = cnt_inc;
                end else begin
                    count_next = '0;
                    emit       = 1'b1;
                    if (len_shift > MAX_LEN) begin
                        phase_next = PH_SYNC;
                        ev         = EV_ERROR;
                        err        = ERR_TOO_BIG;
                        last       = 1'b1;
                    end else if (len_shift == '0) begin
                        phase_next = PH_SYNC;
                        last       = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit = 1'b1;
                ev   = EV_PAYLOAD;
                if (LEN_W'(cnt_inc) >= length_reg) begin
                    count_next = '0;
                    if (crc_eff != '0) begin
                        phase_next = PH_CRC;
                    end else begin
                        phase_next = PH_SYNC;
                        last       = 1'b1;
                    end
                end else begin
                    count_next = cnt_inc;
                end
            end
            PH_CRC: begin
                emit = 1'b1;
                ev   = EV_CRC;
                // effective length is read each beat, so lowering it mid-frame ends the crc bytes early
                if (cnt_inc >= CNT_W'(crc_eff)) begin
                    count_next = '0;
                    phase_next = PH_SYNC;
                    last       = 1'b1;
                end else begin
                    count_next = cnt_inc;
                end
            end
            default: begin
                phase_next = PH_SYNC;
            end
        endcase
    end

    // result uses the header registers as updated by this beat
    always_comb begin
        res.event_res    = ev;
        res.data_byte    = (ev == EV_PAYLOAD || ev == EV_CRC) ? in_byte : '0;
        res.msg_uuid     = hdr ? uuid_reg : '0;
        res.msg_type     = hdr ? type_next : '0;
        res.encrypt_flag = hdr ? flag_reg : '0;
        res.command_id   = hdr ? cmd_reg : '0;
        res.payload_len  = '0;
        if (hdr) begin
            res.payload_len = (len_shift > LEN_FIELD_MAX || phase_reg != PH_LEN)
                ? ((phase_reg == PH_LEN) ? LEN_FIELD_MAX[PLEN_W-1:0] : len_sat)
                : len_shift[PLEN_W-1:0];
        end
        res.error_code   = err;
        res.frame_last   = last;
    end

    assign res_valid = in_valid && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC;
            count_reg      <= '0;
            sync_hi_reg    <= '0;
            uuid_reg       <= '0;
            type_reg       <= '0;
            flag_reg       <= '0;
            cmd_reg        <= '0;
            length_reg     <= '0;
            crc_len_reg    <= CRC_LEN_RST;
            type_count_reg <= TYPE_COUNT_RST;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                sync_hi_reg <= sync_hi_next;
                uuid_reg    <= uuid_next;
                type_reg    <= type_next;
                flag_reg    <= flag_next;
                cmd_reg     <= cmd_next;
                length_reg  <= length_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CRC_LEN) begin
                    crc_len_reg <= cfg_data[CRC_LEN_W-1:0];
                end else if (cfg_index == CFG_TYPE_COUNT) begin
                    type_count_reg <= cfg_data[TYPE_W-1:0];
                end
            end
        end
    end

    a_payload_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> (length_reg != '0 && length_reg <= MAX_LEN))
        else $error("payload phase with out-of-range length");

    a_crc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CRC |-> count_reg < CNT_W'(4))
        else $error("crc byte count beyond four");

    a_sync_err_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && phase_reg == PH_SYNC) |-> (res.event_res == EV_ERROR && !res.frame_last))
        else $error("sync pair result is not a plain error");

    a_last_to_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid && res.frame_last) |=> phase_reg == PH_SYNC)
        else $error("frame ended without returning to sync");

endmodule

// ===== rtl/rfd_out_stage.sv =====
// Result register of the deframer and packing onto the result channel.
// Depends on rfd_pkg.
module rfd_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          res_valid,
    input  rfd_pkg::result_t              res,
    output logic                          advance,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rfd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [rfd_pkg::EVENT_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import rfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign advance = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance) begin
            valid_next = res_valid;
            if (res_valid) begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tlast  = res_reg.frame_last;
    assign m_tdata  = {1'b0,
                       res_reg.error_code,
                       res_reg.payload_len,
                       res_reg.command_id,
                       res_reg.encrypt_flag,
                       res_reg.msg_type,
                       res_reg.msg_uuid,
                       res_reg.data_byte};

endmodule

// ===== bench/tb_rpc_frame_deframer.sv =====
// Testbench for rpc_frame_deframer: byte stream in, parse results out, with
// a local predictor of the deframer, random idling on both sides and register phases.
// Depends on rfd_pkg and the rpc_frame_deframer RTL.
module tb_rpc_frame_deframer;
    import rfd_pkg::*;

    localparam int unsigned LIMIT      = 600000;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned PAIR_BYTES = 2;
    localparam int unsigned RAND_ITEMS = 175;
    localparam int unsigned HOLD_LEN   = 400;

    // indexes past the register list, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [2:0] {
        PH_SYNC, PH_UUID, PH_TYPE, PH_FLAG, PH_CMD, PH_LEN, PH_PAYLOAD, PH_CRC
    } phase_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [EVENT_W-1:0]    m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    rpc_frame_deframer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of registers and parser state
    logic [CRC_LEN_W-1:0] crc_cfg = CRC_LEN_RST;
    logic [TYPE_W-1:0]    tc_cfg  = TYPE_COUNT_RST;
    phase_t               ph      = PH_SYNC;
    logic [PLEN_W-1:0]    cnt     = '0;
    logic [15:0]          sync_sr = '0;
    logic [UUID_W-1:0]    uuid_q  = '0;
    logic [TYPE_W-1:0]    type_q  = '0;
    logic [FLAG_W-1:0]    flag_q  = '0;
    logic [CMD_W-1:0]     cmd_q   = '0;
    logic [LEN_W-1:0]     len_q   = '0;

    logic [BYTE_W-1:0] rx_bytes_q[$];
    result_t           expected_q[$];

    int unsigned pushed_n   = 0;
    int unsigned errors     = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned hold_asks  = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    bit          idle_on    = 1'b1;
    bit          s_fire     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned crc_bytes();
        return (crc_cfg > CRC_LEN_MAX) ? 32'(CRC_LEN_MAX) : 32'(crc_cfg);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic result_t make_result(logic [EVENT_W-1:0] ev, logic [BYTE_W-1:0] d,
                                            logic [ERR_W-1:0] code, logic last, bit hdr);
        result_t r;
        r.event_res    = ev;
        r.data_byte    = d;
        r.msg_uuid     = hdr ? uuid_q : '0;
        r.msg_type     = hdr ? type_q : '0;
        r.encrypt_flag = hdr ? flag_q : '0;
        r.command_id   = hdr ? cmd_q  : '0;
        r.payload_len  = !hdr ? '0 :
                         (len_q > LEN_FIELD_MAX) ? PLEN_W'(LEN_FIELD_MAX) : PLEN_W'(len_q);
        r.error_code   = code;
        r.frame_last   = last;
        return r;
    endfunction

    // advances the predictor by one byte; emitted is set when a result follows
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b, output bit emitted,
                                         output result_t r);
        emitted = 1'b0;
        r       = '0;
        case (ph)
            PH_SYNC: begin
                sync_sr = {sync_sr[7:0], b};
                cnt++;
                if (cnt >= PAIR_BYTES) begin
                    cnt = '0;
                    if (sync_sr == SYNC_WORD) begin
                        uuid_q = '0;
                        len_q  = '0;
                        ph     = PH_UUID;
                    end else begin
                        emitted = 1'b1;
                        r = make_result(EV_ERROR, '0, ERR_SYNC, 1'b0, 1'b0);
                    end
                end
            end
            PH_UUID: begin
                uuid_q = {uuid_q[7:0], b};
                cnt++;
                if (cnt >= 2) begin
                    cnt = '0;
                    ph  = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_q = b;
                cnt    = '0;
                if (b < tc_cfg) begin
                    ph = PH_FLAG;
                end else begin
                    ph      = PH_SYNC;
                    emitted = 1'b1;
                    r = make_result(EV_ERROR, '0, ERR_TYPE, 1'b1, 1'b1);
                end
            end
            PH_FLAG: begin
                flag_q = b;
                cnt    = '0;
                ph     = PH_CMD;
            end
            PH_CMD: begin
                cmd_q = {cmd_q[7:0], b};
                cnt++;
                if (cnt >= 2) begin
                    cnt = '0;
                    ph  = PH_LEN;
                end
            end
            PH_LEN: begin
                len_q = {len_q[23:0], b};
                cnt++;
                if (cnt >= 4) begin
                    cnt     = '0;
                    emitted = 1'b1;
                    if (len_q > MAX_PAYLOAD_DEF) begin
                        ph = PH_SYNC;
                        r  = make_result(EV_ERROR, '0, ERR_TOO_BIG, 1'b1, 1'b1);
                    end else if (len_q == 0) begin
                        ph = PH_SYNC;
                        r  = make_result(EV_HEADER, '0, ERR_NONE, 1'b1, 1'b1);
                    end else begin
                        ph = PH_PAYLOAD;
                        r  = make_result(EV_HEADER, '0, ERR_NONE, 1'b0, 1'b1);
                    end
                end
            end
            PH_PAYLOAD: begin
                cnt++;
                emitted = 1'b1;
                if (cnt >= len_q) begin
                    cnt = '0;
                    ph  = (crc_bytes() > 0) ? PH_CRC : PH_SYNC;
                    r   = make_result(EV_PAYLOAD, b, ERR_NONE, crc_bytes() == 0, 1'b1);
                end else begin
                    r = make_result(EV_PAYLOAD, b, ERR_NONE, 1'b0, 1'b1);
                end
            end
            default: begin
                cnt++;
                emitted = 1'b1;
                if (cnt >= crc_bytes()) begin
                    cnt = '0;
                    ph  = PH_SYNC;
                    r   = make_result(EV_CRC, b, ERR_NONE, 1'b1, 1'b1);
                end else begin
                    r = make_result(EV_CRC, b, ERR_NONE, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, seen);
        end
    endfunction

    // sender: holds a beat until taken, idles in bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // beat still pending
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 11) - 1;
            s_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() > 0) begin
            s_tdata  <= rx_bytes_q.pop_front();
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus a long hold-off when the test asks for one
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        bit      has;
        result_t r;
        result_t want;
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            deframe_byte(s_tdata, has, r);
            if (has)
                expected_q.push_back(r);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected: tuser %0d tdata 0x%0h tlast %0d",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = expected_q.pop_front();
                check_field("event_res",    want.event_res,    m_tuser);
                check_field("data_byte",    want.data_byte,    m_tdata[7:0]);
                check_field("msg_uuid",     want.msg_uuid,     m_tdata[23:8]);
                check_field("msg_type",     want.msg_type,     m_tdata[31:24]);
                check_field("encrypt_flag", want.encrypt_flag, m_tdata[39:32]);
                check_field("command_id",   want.command_id,   m_tdata[55:40]);
                check_field("payload_len",  want.payload_len,  m_tdata[68:56]);
                check_field("error_code",   want.error_code,   m_tdata[70:69]);
                check_field("tdata pad",    32'd0,             m_tdata[71]);
                check_field("frame_last",   want.frame_last,   m_tlast);
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        rx_bytes_q.push_back(b);
        pushed_n++;
    endtask

    task automatic queue_bad_type(input logic [TYPE_W-1:0] typ);
        push_byte(SYNC_WORD[15:8]);
        push_byte(SYNC_WORD[7:0]);
        push_byte(rand_byte());
        push_byte(rand_byte());
        push_byte(typ);
    endtask

    // full header, then body_n payload bytes and crc_n trailing bytes
    task automatic queue_frame(input logic [TYPE_W-1:0] typ, input logic [LEN_W-1:0] len,
                               input int unsigned body_n, input int unsigned crc_n);
        push_byte(SYNC_WORD[15:8]);
        push_byte(SYNC_WORD[7:0]);
        repeat (2) push_byte(rand_byte());
        push_byte(typ);
        repeat (3) push_byte(rand_byte());
        push_byte(len[31:24]);
        push_byte(len[23:16]);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        repeat (body_n + crc_n) push_byte(rand_byte());
    endtask

    task automatic queue_random_traffic(input int unsigned n);
        int unsigned  start;
        int unsigned  pick;
        logic [31:0]  len;
        logic [7:0]   typ;
        logic [7:0]   b;
        start = pushed_n;
        while (pushed_n - start < n) begin
            pick = $urandom_range(0, 99);
            typ  = (tc_cfg == 0) ? 8'd0 : 8'($urandom_range(0, tc_cfg - 1));
            if (pick < 68 && tc_cfg != 0) begin
                case ($urandom_range(0, 15))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = $urandom_range(100, 300);
                    default: len = $urandom_range(1, 24);
                endcase
                queue_frame(typ, len, len, (len == 0) ? 0 : crc_bytes());
            end else if (pick < 78) begin
                queue_bad_type(8'($urandom_range(tc_cfg, 255)));
            end else if (pick < 86) begin
                case ($urandom_range(0, 3))
                    0:       len = MAX_PAYLOAD_DEF + 1;
                    1:       len = 32'hFFFF_FFFF;
                    2:       len = $urandom_range(MAX_PAYLOAD_DEF + 1, 8200);
                    default: len = $urandom_range(MAX_PAYLOAD_DEF + 1, 32'hFFFF_FFFF);
                endcase
                queue_frame(typ, len, 0, 0);
            end else if (pick < 95) begin
                // near-miss and random sync pairs
                repeat ($urandom_range(1, 3)) begin
                    b = rand_byte();
                    case ($urandom_range(0, 2))
                        0: begin
                            push_byte(SYNC_WORD[15:8]);
                            push_byte((b == SYNC_WORD[7:0]) ? b - 8'd1 : b);
                        end
                        1: begin
                            push_byte((b == SYNC_WORD[15:8]) ? b + 8'd1 : b);
                            push_byte(SYNC_WORD[7:0]);
                        end
                        default: begin
                            push_byte(b);
                            push_byte(rand_byte());
                        end
                    endcase
                end
            end else begin
                // one-byte slip ahead of a frame, realigned by a trailing byte
                push_byte(rand_byte());
                len = $urandom_range(0, 8);
                queue_frame(typ, len, len, (len == 0) ? 0 : crc_bytes());
                push_byte(rand_byte());
            end
        end
    endtask

    // sender drained, every result taken, then room for bytes still in the pipe
    task automatic wait_idle();
        do @(posedge aclk);
        while (rx_bytes_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_CRC_LEN:    crc_cfg = val[CRC_LEN_W-1:0];
            CFG_TYPE_COUNT: tc_cfg  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    logic [CRC_LEN_W-1:0] crc_list [6] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd3};
    logic [TYPE_W-1:0]    tc_list  [6] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd16, 8'd0};

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        push_byte(8'h00);
        push_byte(8'h00);
        queue_bad_type(TYPE_COUNT_RST);
        queue_frame(8'd1, 32'd0, 0, 0);
        queue_frame(8'd0, 32'hFFFF_FFFF, 0, 0);
        queue_frame(8'd0, 32'd1, 1, 0);
        wait_idle();

        write_reg(CFG_CRC_LEN, 8'd4);
        write_reg(CFG_TYPE_COUNT, 8'd255);
        write_reg(CFG_SPARE_2, rand_byte());
        write_reg(CFG_SPARE_3, rand_byte());
        // receiver holds off while a long frame streams in
        hold_asks++;
        queue_frame(8'd254, HOLD_LEN, HOLD_LEN, 4);
        queue_bad_type(8'd255);
        queue_frame(8'd0, MAX_PAYLOAD_DEF + 1, 0, 0);
        wait_idle();

        // crc_len lowered in the middle of the crc bytes
        queue_frame(8'd3, 32'd3, 3, 1);
        wait_idle();
        write_reg(CFG_CRC_LEN, 8'd2);
        push_byte(rand_byte());
        // crc disabled in the middle of the payload
        queue_frame(8'd5, 32'd5, 2, 0);
        wait_idle();
        write_reg(CFG_CRC_LEN, 8'd0);
        repeat (3) push_byte(rand_byte());
        wait_idle();

        // no valid type at all; crc_len above four
        write_reg(CFG_TYPE_COUNT, 8'd0);
        write_reg(CFG_CRC_LEN, 8'd7);
        queue_bad_type(8'h00);
        queue_bad_type(8'h80);
        wait_idle();
        write_reg(CFG_TYPE_COUNT, 8'd1);
        queue_frame(8'd0, 32'd2, 2, 4);
        wait_idle();

        for (int i = 0; i < 6; i++) begin
            write_reg(CFG_CRC_LEN, CFG_DATA_W'(crc_list[i]));
            write_reg(CFG_TYPE_COUNT,
                      (tc_list[i] == 0) ? 8'($urandom_range(1, 255)) : tc_list[i]);
            if (i == 5)
                idle_on = 1'b0;
            queue_random_traffic(RAND_ITEMS);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== rpc_frame_deframer.f =====
rtl/rfd_pkg.sv
rtl/rfd_in_stage.sv
rtl/rfd_parser.sv
rtl/rfd_out_stage.sv
rtl/rpc_frame_deframer.sv
bench/tb_rpc_frame_deframer.sv
